/* rtl/iep_pkg.sv */
// Shared types and constants of the isolated-error predecoder.
// No dependencies; iep_if, the top level and the testbench use its scoped names.
package iep_pkg;

  localparam int unsigned DEF_DET_COUNT  = 1024;
  localparam int unsigned DEF_SLOT_COUNT = 16;
  localparam int unsigned DEF_OBS_COUNT  = 8;

  localparam int unsigned DET_W    = 10;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned FLIPS_W  = 8;
  localparam int unsigned COUNT_W  = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [1:0]         DEG_SAT   = 2'd2;
  localparam logic [1:0]         DEG_ONE   = 2'd1;

  typedef enum logic [1:0] {
    ACT_LOAD_EDGE = 2'd0,
    ACT_LOAD_SYN  = 2'd1,
    ACT_RUN       = 2'd2,
    ACT_QUERY     = 2'd3
  } action_e;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  typedef struct packed {
    logic [DET_W-1:0]    nb;
    logic                bnd;
    logic                valid;
    logic [WEIGHT_W-1:0] weight;
    logic [FLIPS_W-1:0]  flips;
  } edge_t;

  localparam int unsigned EDGE_W = $bits(edge_t);

  typedef struct packed {
    logic [1:0]          action;
    logic [DET_W-1:0]    detector;
    logic [SLOT_W-1:0]   slot;
    logic [DET_W-1:0]    neighbour;
    logic                to_boundary;
    logic                entry_valid;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [FLIPS_W-1:0]  edge_flips;
    logic                syndrome_bit;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [DET_W-1:0]    report_detector;
    logic                matched;
    logic [DET_W-1:0]    partner;
    logic                partner_is_boundary;
    logic [WEIGHT_W-1:0] pair_weight;
    logic [FLIPS_W-1:0]  pair_flips;
    logic                residual_bit;
    logic [FLIPS_W-1:0]  total_flips;
    logic [COUNT_W-1:0]  removed_pairs;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_PAR_RD,
    ST_PAR_AC,
    ST_B_DET,
    ST_B_SYN,
    ST_B_ADJ,
    ST_B_EDG,
    ST_B_EVL,
    ST_B_WR,
    ST_C_DET,
    ST_C_CHK,
    ST_C_EDG,
    ST_C_EVL,
    ST_C_WI,
    ST_C_RN,
    ST_C_WN,
    ST_RUN_OUT,
    ST_Q_DET,
    ST_Q_CHK,
    ST_Q_EDG,
    ST_Q_OUT
  } state_e;

  function automatic logic [1:0] sat_inc(input logic [1:0] v);
    return (v < DEG_SAT) ? v + 2'd1 : DEG_SAT;
  endfunction

endpackage

/* rtl/iep_if.sv */
// Valid/ready channel interfaces for input and result words.
// Depends on iep_pkg for the payload structs.
interface iep_in_if;
  logic               valid;
  logic               ready;
  iep_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface iep_out_if;
  logic               valid;
  logic               ready;
  iep_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/iep_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module iep_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* rtl/isolated_error_predecoder_unit.sv */
// Isolated-error predecoder: top level with sequencer and state memories.
// Depends on iep_pkg, iep_if (iep_in_if, iep_out_if) and iep_ram.
//
// Use: one input channel (in_i) carries command words: load an adjacency
// entry, load a syndrome bit, run the filter, or query a detector. Loads give
// no result word; run and query each give one word on out_o.
// Loads are written as they are taken. A query reads the detector word, then
// the paired adjacency entry when the detector carries a pair, and then fills
// the output register. A run walks the detectors three times: parity, degree
// count (reading each adjacency slot of each flipped detector) and removal;
// its passes are sequential, bounded by the single read port of the
// adjacency RAM and the detector RAM in the read-modify-write sequence.
// One word at a time is in flight; a new word is taken only when the output
// register is empty or being emptied, so a stalled receiver holds the block.
// After reset a clearing pass zeroes the syndrome and detector memories; no
// word is taken during it. The adjacency memory is not cleared and must be
// written before it is read.
module isolated_error_predecoder_unit #(
  parameter int unsigned DET_COUNT  = iep_pkg::DEF_DET_COUNT,
  parameter int unsigned SLOT_COUNT = iep_pkg::DEF_SLOT_COUNT,
  parameter int unsigned OBS_COUNT  = iep_pkg::DEF_OBS_COUNT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  iep_in_if.sink    in_i,
  iep_out_if.source out_o
);
  localparam int unsigned AW     = $clog2(DET_COUNT);
  localparam int unsigned SW     = $clog2(SLOT_COUNT);
  localparam int unsigned ADEPTH = DET_COUNT * SLOT_COUNT;
  localparam int unsigned ADDR_W = $clog2(ADEPTH);
  // detector word: degree, companion slot, residual, matched
  localparam int unsigned DW     = SW + 4;
  localparam logic [AW-1:0] LAST_DET = AW'(DET_COUNT - 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
  localparam logic [iep_pkg::FLIPS_W-1:0] OBS_MASK = (OBS_COUNT >= 8) ? 8'hFF :
    8'((1 << OBS_COUNT) - 1);

  function automatic logic [ADDR_W-1:0] adj_addr(input logic [AW-1:0] d,
                                                 input logic [SW-1:0] s);
    return ADDR_W'(d) * ADDR_W'(SLOT_COUNT) + ADDR_W'(s);
  endfunction

  iep_pkg::state_e state_q, state_d;

  logic [AW-1:0]                idx_q;
  logic [SW-1:0]                slot_q;
  logic [iep_pkg::DET_W-1:0]    det_q;
  logic                         det_ok_q;
  logic                         parity_q;
  logic                         syn_i_q;
  logic [1:0]                   deg_q;
  logic [SW-1:0]                comp_q;
  logic [1:0]                   bcnt_q;
  iep_pkg::edge_t               edge_q;
  logic [DW-1:0]                cur_q;
  logic [iep_pkg::FLIPS_W-1:0]  flips_q;
  logic [iep_pkg::COUNT_W-1:0]  removed_q;
  logic                         out_valid_q;
  iep_pkg::out_item_t           out_data_q;

  // memory ports
  logic                 adj_we;
  logic [ADDR_W-1:0]    adj_waddr, adj_raddr;
  iep_pkg::edge_t       adj_wdata;
  logic [iep_pkg::EDGE_W-1:0] adj_rd_raw;
  iep_pkg::edge_t       adj_rd;
  logic                 syn_we;
  logic [AW-1:0]        syn_waddr, syna_raddr, synb_raddr;
  logic                 syn_wdata, syna_rd, synb_rd;
  logic                 det_we;
  logic [AW-1:0]        det_waddr, det_raddr;
  logic [DW-1:0]        det_wdata, det_rd;

  logic in_ready, in_acc;
  logic in_det_ok, in_slot_ok;
  logic idx_last;
  logic edge_active, c_take, c_ok;
  iep_pkg::in_item_t in_w;

  assign in_w       = in_i.data;
  assign in_ready   = (state_q == iep_pkg::ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_i.ready = in_ready;
  assign in_acc     = in_i.valid && in_ready;
  assign in_det_ok  = 32'(in_w.detector) < DET_COUNT;
  assign in_slot_ok = 32'(in_w.slot) < SLOT_COUNT;
  assign idx_last   = (idx_q == LAST_DET);
  assign adj_rd     = iep_pkg::edge_t'(adj_rd_raw);

  // degree pass: does the latched edge count as an active neighbour
  assign edge_active = edge_q.valid &&
    (edge_q.bnd ? parity_q : ((32'(edge_q.nb) < DET_COUNT) && synb_rd));
  // removal pass: detector is a candidate, and the pair holds
  assign c_take = det_rd[1] && (det_rd[DW-1 -: 2] == iep_pkg::DEG_ONE);
  assign c_ok   = edge_q.bnd ? (bcnt_q == iep_pkg::DEG_ONE) :
    ((32'(edge_q.nb) < DET_COUNT) && (det_rd[DW-1 -: 2] == iep_pkg::DEG_ONE));

  iep_ram #(.WIDTH(iep_pkg::EDGE_W), .DEPTH(ADEPTH)) u_adj_ram (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .raddr_i(adj_raddr), .rdata_o(adj_rd_raw)
  );
  // two copies of the syndrome so a detector and its neighbour read together
  iep_ram #(.WIDTH(1), .DEPTH(DET_COUNT)) u_syna_ram (
    .clk_i, .we_i(syn_we), .waddr_i(syn_waddr), .wdata_i(syn_wdata),
    .raddr_i(syna_raddr), .rdata_o(syna_rd)
  );
  iep_ram #(.WIDTH(1), .DEPTH(DET_COUNT)) u_synb_ram (
    .clk_i, .we_i(syn_we), .waddr_i(syn_waddr), .wdata_i(syn_wdata),
    .raddr_i(synb_raddr), .rdata_o(synb_rd)
  );
  iep_ram #(.WIDTH(DW), .DEPTH(DET_COUNT)) u_det_ram (
    .clk_i, .we_i(det_we), .waddr_i(det_waddr), .wdata_i(det_wdata),
    .raddr_i(det_raddr), .rdata_o(det_rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      iep_pkg::ST_CLR:     if (idx_last) state_d = iep_pkg::ST_IDLE;
      iep_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_w.action == iep_pkg::ACT_RUN) state_d = iep_pkg::ST_PAR_RD;
          else if (in_w.action == iep_pkg::ACT_QUERY) state_d = iep_pkg::ST_Q_DET;
        end
      end
      iep_pkg::ST_PAR_RD:  state_d = iep_pkg::ST_PAR_AC;
      iep_pkg::ST_PAR_AC:  state_d = idx_last ? iep_pkg::ST_B_DET : iep_pkg::ST_PAR_RD;
      iep_pkg::ST_B_DET:   state_d = iep_pkg::ST_B_SYN;
      iep_pkg::ST_B_SYN:   state_d = syna_rd ? iep_pkg::ST_B_ADJ : iep_pkg::ST_B_WR;
      iep_pkg::ST_B_ADJ:   state_d = iep_pkg::ST_B_EDG;
      iep_pkg::ST_B_EDG:   state_d = iep_pkg::ST_B_EVL;
      iep_pkg::ST_B_EVL:   state_d = (slot_q == LAST_SLOT) ? iep_pkg::ST_B_WR : iep_pkg::ST_B_ADJ;
      iep_pkg::ST_B_WR:    state_d = idx_last ? iep_pkg::ST_C_DET : iep_pkg::ST_B_DET;
      iep_pkg::ST_C_DET:   state_d = iep_pkg::ST_C_CHK;
      iep_pkg::ST_C_CHK: begin
        if (c_take) state_d = iep_pkg::ST_C_EDG;
        else state_d = idx_last ? iep_pkg::ST_RUN_OUT : iep_pkg::ST_C_DET;
      end
      iep_pkg::ST_C_EDG:   state_d = iep_pkg::ST_C_EVL;
      iep_pkg::ST_C_EVL: begin
        if (c_ok) state_d = iep_pkg::ST_C_WI;
        else state_d = idx_last ? iep_pkg::ST_RUN_OUT : iep_pkg::ST_C_DET;
      end
      iep_pkg::ST_C_WI: begin
        if (!edge_q.bnd) state_d = iep_pkg::ST_C_RN;
        else state_d = idx_last ? iep_pkg::ST_RUN_OUT : iep_pkg::ST_C_DET;
      end
      iep_pkg::ST_C_RN:    state_d = iep_pkg::ST_C_WN;
      iep_pkg::ST_C_WN:    state_d = idx_last ? iep_pkg::ST_RUN_OUT : iep_pkg::ST_C_DET;
      iep_pkg::ST_RUN_OUT: state_d = iep_pkg::ST_IDLE;
      iep_pkg::ST_Q_DET:   state_d = iep_pkg::ST_Q_CHK;
      iep_pkg::ST_Q_CHK:   state_d = (det_ok_q && det_rd[0]) ? iep_pkg::ST_Q_EDG :
                                                                iep_pkg::ST_Q_OUT;
      iep_pkg::ST_Q_EDG:   state_d = iep_pkg::ST_Q_OUT;
      iep_pkg::ST_Q_OUT:   state_d = iep_pkg::ST_IDLE;
      default:             state_d = iep_pkg::ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    adj_we     = 1'b0;
    adj_waddr  = adj_addr(AW'(in_w.detector), SW'(in_w.slot));
    adj_wdata  = '{nb: in_w.neighbour, bnd: in_w.to_boundary, valid: in_w.entry_valid,
                   weight: in_w.edge_weight, flips: in_w.edge_flips & OBS_MASK};
    adj_raddr  = adj_addr(idx_q, slot_q);
    syn_we     = 1'b0;
    syn_waddr  = AW'(in_w.detector);
    syn_wdata  = in_w.syndrome_bit;
    syna_raddr = idx_q;
    synb_raddr = AW'(adj_rd.nb);
    det_we     = 1'b0;
    det_waddr  = idx_q;
    det_wdata  = '0;
    det_raddr  = idx_q;
    case (state_q)
      iep_pkg::ST_CLR: begin
        syn_we    = 1'b1;
        syn_waddr = idx_q;
        syn_wdata = 1'b0;
        det_we    = 1'b1;
      end
      iep_pkg::ST_IDLE: begin
        adj_we = in_acc && (in_w.action == iep_pkg::ACT_LOAD_EDGE) && in_det_ok && in_slot_ok;
        syn_we = in_acc && (in_w.action == iep_pkg::ACT_LOAD_SYN) && in_det_ok;
      end
      iep_pkg::ST_B_WR: begin
        det_we    = 1'b1;
        det_wdata = {deg_q, comp_q, syn_i_q, 1'b0};
      end
      iep_pkg::ST_C_CHK:   adj_raddr = adj_addr(idx_q, det_rd[2 +: SW]);
      iep_pkg::ST_C_EDG:   det_raddr = AW'(adj_rd.nb);
      iep_pkg::ST_C_WI: begin
        det_we    = 1'b1;
        det_wdata = {cur_q[DW-1:2], ~cur_q[1], 1'b1};
      end
      iep_pkg::ST_C_RN:    det_raddr = AW'(edge_q.nb);
      iep_pkg::ST_C_WN: begin
        det_we    = 1'b1;
        det_waddr = AW'(edge_q.nb);
        det_wdata = {det_rd[DW-1:2], ~det_rd[1], det_rd[0]};
      end
      iep_pkg::ST_Q_DET:   det_raddr = AW'(det_q);
      iep_pkg::ST_Q_CHK:   adj_raddr = adj_addr(AW'(det_q), det_rd[2 +: SW]);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iep_pkg::ST_CLR;
      idx_q       <= '0;
      slot_q      <= '0;
      parity_q    <= 1'b0;
      bcnt_q      <= '0;
      flips_q     <= '0;
      removed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        iep_pkg::ST_CLR: idx_q <= idx_last ? '0 : idx_q + 1'b1;
        iep_pkg::ST_IDLE: begin
          if (in_acc) begin
            det_q    <= in_w.detector;
            det_ok_q <= in_det_ok;
            idx_q    <= '0;
            if (in_w.action == iep_pkg::ACT_RUN) begin
              parity_q  <= 1'b0;
              bcnt_q    <= '0;
              flips_q   <= '0;
              removed_q <= '0;
            end
          end
        end
        iep_pkg::ST_PAR_AC: begin
          parity_q <= parity_q ^ syna_rd;
          idx_q    <= idx_last ? '0 : idx_q + 1'b1;
        end
        iep_pkg::ST_B_SYN: begin
          syn_i_q <= syna_rd;
          deg_q   <= '0;
          comp_q  <= '0;
          slot_q  <= '0;
        end
        iep_pkg::ST_B_EDG: edge_q <= adj_rd;
        iep_pkg::ST_B_EVL: begin
          if (edge_active) begin
            deg_q  <= iep_pkg::sat_inc(deg_q);
            comp_q <= slot_q;
            if (edge_q.bnd) bcnt_q <= iep_pkg::sat_inc(bcnt_q);
          end
          slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
        end
        iep_pkg::ST_B_WR: idx_q <= idx_last ? '0 : idx_q + 1'b1;
        iep_pkg::ST_C_CHK: begin
          cur_q <= det_rd;
          if (!c_take) idx_q <= idx_q + 1'b1;
        end
        iep_pkg::ST_C_EDG: edge_q <= adj_rd;
        iep_pkg::ST_C_EVL: if (!c_ok) idx_q <= idx_q + 1'b1;
        iep_pkg::ST_C_WI: begin
          flips_q <= flips_q ^ edge_q.flips;
          if (removed_q != iep_pkg::COUNT_MAX) removed_q <= removed_q + 1'b1;
          if (edge_q.bnd) idx_q <= idx_q + 1'b1;
        end
        iep_pkg::ST_C_WN: idx_q <= idx_q + 1'b1;
        iep_pkg::ST_RUN_OUT: begin
          out_valid_q <= 1'b1;
          out_data_q  <= '0;
          out_data_q.kind          <= iep_pkg::KIND_SUMMARY;
          out_data_q.total_flips   <= flips_q;
          out_data_q.removed_pairs <= removed_q;
        end
        iep_pkg::ST_Q_CHK: cur_q <= det_rd;
        iep_pkg::ST_Q_EDG: edge_q <= adj_rd;
        iep_pkg::ST_Q_OUT: begin
          out_valid_q <= 1'b1;
          out_data_q  <= '0;
          out_data_q.kind            <= iep_pkg::KIND_REPORT;
          out_data_q.report_detector <= det_q;
          out_data_q.total_flips     <= flips_q;
          out_data_q.removed_pairs   <= removed_q;
          if (det_ok_q) begin
            out_data_q.residual_bit <= cur_q[1];
            if (cur_q[0]) begin
              out_data_q.matched             <= 1'b1;
              out_data_q.partner             <= edge_q.bnd ? '0 : edge_q.nb;
              out_data_q.partner_is_boundary <= edge_q.bnd;
              out_data_q.pair_weight         <= edge_q.weight;
              out_data_q.pair_flips          <= edge_q.flips;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // no word is taken while the memories are being cleared
  a_clr_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iep_pkg::ST_CLR) |-> !in_i.ready)
    else $error("input taken during clearing pass");

  // a result word appears only from a summary or report step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == iep_pkg::ST_RUN_OUT ||
                            $past(state_q) == iep_pkg::ST_Q_OUT))
    else $error("result word without a producing step");

  // a new word is never taken while a stalled result would be overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken over a stalled result");
endmodule

/* tb/testbench.sv */
// Self-checking testbench for the isolated-error predecoder unit.
// Depends on iep_pkg, iep_if and the unit itself; drives command words and
// checks every result word against a behavioral prediction of the filter.
module testbench;

  localparam int unsigned NDET = iep_pkg::DEF_DET_COUNT;
  localparam int unsigned NSLOT = iep_pkg::DEF_SLOT_COUNT;
  localparam int unsigned SW = iep_pkg::SLOT_W;
  localparam int unsigned DW = iep_pkg::DET_W;
  localparam int unsigned IN_W = $bits(iep_pkg::in_item_t);
  localparam int unsigned POOL_N = 20;
  localparam int unsigned RAND_ITEMS = 340;
  localparam int unsigned SETTLE = 40;
  localparam int unsigned EXP_DEPTH = 16;

  logic clk_i;
  logic rst_ni;

  iep_in_if  cmd_ch ();
  iep_out_if res_ch ();

  isolated_error_predecoder_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  // Predicted state of the block.
  iep_pkg::edge_t              graph_q [NDET*NSLOT];
  logic                        syn_q   [NDET];
  logic [1:0]                  deg_q   [NDET];
  logic [SW-1:0]               comp_q  [NDET];
  logic                        resid_q [NDET];
  logic                        pair_q  [NDET];
  logic [1:0]                  bnd_cnt;
  logic [iep_pkg::FLIPS_W-1:0] flip_acc;
  logic [iep_pkg::COUNT_W-1:0] removed_cnt;

  // Slots written per detector; a flipped detector must have all of them.
  logic [NSLOT-1:0] written_q [NDET];
  int unsigned pool [POOL_N];

  // Expected result words, oldest at exp_rd.
  iep_pkg::out_item_t exp_fifo [EXP_DEPTH];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  int unsigned errors = 0;
  bit no_gaps = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [1:0] bump(input logic [1:0] v);
    return (v == 2'd2) ? 2'd2 : v + 2'd1;
  endfunction

  // Apply the filter pass to the predicted state.
  function automatic void filter_pass();
    logic parity;
    iep_pkg::edge_t e;
    logic ok;
    parity = 1'b0;
    for (int i = 0; i < NDET; i++) parity ^= syn_q[i];
    bnd_cnt = '0;
    flip_acc = '0;
    removed_cnt = '0;
    for (int i = 0; i < NDET; i++) begin
      deg_q[i] = '0;
      comp_q[i] = '0;
      pair_q[i] = 1'b0;
      resid_q[i] = syn_q[i];
    end
    for (int i = 0; i < NDET; i++) begin
      if (!syn_q[i]) continue;
      for (int s = 0; s < NSLOT; s++) begin
        e = graph_q[i*NSLOT + s];
        if (!e.valid) continue;
        if (e.bnd) begin
          if (parity) begin
            deg_q[i] = bump(deg_q[i]);
            bnd_cnt = bump(bnd_cnt);
            comp_q[i] = SW'(s);
          end
        end else if (syn_q[e.nb]) begin
          deg_q[i] = bump(deg_q[i]);
          comp_q[i] = SW'(s);
        end
      end
    end
    for (int i = 0; i < NDET; i++) begin
      if (!resid_q[i] || deg_q[i] != 2'd1) continue;
      e = graph_q[i*NSLOT + comp_q[i]];
      ok = e.bnd ? (bnd_cnt == 2'd1) : (deg_q[e.nb] == 2'd1);
      if (!ok) continue;
      resid_q[i] ^= 1'b1;
      if (!e.bnd) resid_q[e.nb] ^= 1'b1;
      flip_acc ^= e.flips;
      if (removed_cnt != iep_pkg::COUNT_MAX) removed_cnt++;
      pair_q[i] = 1'b1;
    end
  endfunction

  // Update the prediction for one accepted word; queue its result, if any.
  function automatic void predict_word(input iep_pkg::in_item_t w);
    iep_pkg::out_item_t r;
    iep_pkg::edge_t e;
    case (iep_pkg::action_e'(w.action))
      iep_pkg::ACT_LOAD_EDGE: begin
        e.nb = w.neighbour;
        e.bnd = w.to_boundary;
        e.valid = w.entry_valid;
        e.weight = w.edge_weight;
        e.flips = w.edge_flips;
        graph_q[w.detector*NSLOT + w.slot] = e;
        written_q[w.detector][w.slot] = 1'b1;
      end
      iep_pkg::ACT_LOAD_SYN: syn_q[w.detector] = w.syndrome_bit;
      default: begin
        r = '0;
        if (iep_pkg::action_e'(w.action) == iep_pkg::ACT_RUN) begin
          filter_pass();
          r.kind = iep_pkg::KIND_SUMMARY;
        end else begin
          r.kind = iep_pkg::KIND_REPORT;
          r.report_detector = w.detector;
          r.residual_bit = resid_q[w.detector];
          if (pair_q[w.detector]) begin
            e = graph_q[w.detector*NSLOT + comp_q[w.detector]];
            r.matched = 1'b1;
            r.partner = e.bnd ? '0 : e.nb;
            r.partner_is_boundary = e.bnd;
            r.pair_weight = e.weight;
            r.pair_flips = e.flips;
          end
        end
        r.total_flips = flip_acc;
        r.removed_pairs = removed_cnt;
        exp_fifo[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
      end
    endcase
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Send one word: hold it until the block takes it, then predict it.
  task automatic send_word(input iep_pkg::in_item_t w);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= w;
    do @(posedge clk_i); while (!cmd_ch.ready);
    predict_word(w);
  endtask

  task automatic load_edge(input int unsigned det, input int unsigned slot,
                           input int unsigned nb, input logic bnd, input logic vld,
                           input logic [31:0] wt, input logic [7:0] fl);
    iep_pkg::in_item_t w;
    w = '0;
    w.action = iep_pkg::ACT_LOAD_EDGE;
    w.detector = DW'(det);
    w.slot = SW'(slot);
    w.neighbour = DW'(nb);
    w.to_boundary = bnd;
    w.entry_valid = vld;
    w.edge_weight = wt;
    w.edge_flips = fl;
    w.syndrome_bit = 1'($urandom_range(0, 1));
    send_word(w);
  endtask

  // Only fully written detectors may be flipped.
  task automatic load_syn(input int unsigned det, input logic b);
    iep_pkg::in_item_t w;
    w = iep_pkg::in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    w.action = iep_pkg::ACT_LOAD_SYN;
    w.detector = DW'(det);
    w.syndrome_bit = b && (written_q[det] == '1);
    send_word(w);
  endtask

  task automatic run_filter();
    iep_pkg::in_item_t w;
    w = iep_pkg::in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    w.action = iep_pkg::ACT_RUN;
    send_word(w);
  endtask

  task automatic query(input int unsigned det);
    iep_pkg::in_item_t w;
    w = iep_pkg::in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    w.action = iep_pkg::ACT_QUERY;
    w.detector = DW'(det);
    send_word(w);
  endtask

  // Hold the sender until every expected result has come.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    wait (exp_rd == exp_wr);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Result side: stall at random, check each word against the oldest prediction.
  initial begin
    iep_pkg::out_item_t exp_w;
    iep_pkg::out_item_t got;
    int unsigned stall;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      got = res_ch.data;
      if (exp_rd == exp_wr) begin
        report("unexpected word", 64'(got.kind), 64'd0);
      end else begin
        exp_w = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got.kind != exp_w.kind) report("kind", 64'(got.kind), 64'(exp_w.kind));
        if (got.report_detector != exp_w.report_detector)
          report("report_detector", 64'(got.report_detector), 64'(exp_w.report_detector));
        if (got.matched != exp_w.matched)
          report("matched", 64'(got.matched), 64'(exp_w.matched));
        if (got.partner != exp_w.partner)
          report("partner", 64'(got.partner), 64'(exp_w.partner));
        if (got.partner_is_boundary != exp_w.partner_is_boundary)
          report("partner_is_boundary", 64'(got.partner_is_boundary),
                 64'(exp_w.partner_is_boundary));
        if (got.pair_weight != exp_w.pair_weight)
          report("pair_weight", 64'(got.pair_weight), 64'(exp_w.pair_weight));
        if (got.pair_flips != exp_w.pair_flips)
          report("pair_flips", 64'(got.pair_flips), 64'(exp_w.pair_flips));
        if (got.residual_bit != exp_w.residual_bit)
          report("residual_bit", 64'(got.residual_bit), 64'(exp_w.residual_bit));
        if (got.total_flips != exp_w.total_flips)
          report("total_flips", 64'(got.total_flips), 64'(exp_w.total_flips));
        if (got.removed_pairs != exp_w.removed_pairs)
          report("removed_pairs", 64'(got.removed_pairs), 64'(exp_w.removed_pairs));
      end
    end
  end

  // Write every slot of the pool detectors so they may be flipped later.
  task automatic test_pool_setup();
    bit dup;
    pool[0] = 0; pool[1] = 1; pool[2] = 2; pool[3] = 3; pool[4] = NDET - 1;
    for (int k = 5; k < POOL_N; k++) begin
      do begin
        pool[k] = $urandom_range(4, NDET - 2);
        dup = 0;
        for (int j = 5; j < k; j++) if (pool[j] == pool[k]) dup = 1;
      end while (dup);
    end
    for (int k = 0; k < POOL_N; k++)
      for (int s = 0; s < NSLOT; s++)
        load_edge(pool[k], s, $urandom_range(0, NDET - 1), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 3) == 0, $urandom, 8'($urandom));
  endtask

  // Isolated pair, lone boundary pair, self edge, parity and saturation cases.
  task automatic test_directed();
    load_edge(0, 0, 1, 1'b0, 1'b1, 32'hFFFF_FFFF, 8'hFF);
    load_edge(1, NSLOT - 1, 0, 1'b0, 1'b1, 32'hFFFF_FFFF, 8'hFF);
    load_edge(2, 15, 1023, 1'b1, 1'b1, 32'h0, 8'h5A);
    load_edge(3, 5, 3, 1'b0, 1'b1, 32'h1234_5678, 8'hA5);
    load_edge(1023, 7, 1022, 1'b0, 1'b1, 32'h0000_0001, 8'h01);
    for (int k = 0; k < POOL_N; k++) load_syn(pool[k], 1'b0);
    load_syn(0, 1'b1);
    load_syn(1, 1'b1);
    load_syn(2, 1'b1);
    run_filter();
    query(0); query(1); query(2); query(1023);
    load_syn(3, 1'b1);
    run_filter();
    run_filter();
    query(2); query(3);
    // Degree saturation: detector 0 sees 1, 2 and 3.
    load_edge(0, 1, 2, 1'b0, 1'b1, 32'h8000_0000, 8'h80);
    load_edge(0, 2, 3, 1'b0, 1'b1, 32'h7FFF_FFFF, 8'h7F);
    load_syn(1023, 1'b1);
    run_filter();
    query(0); query(1023);
    drain();
  endtask

  // Rounds of graph edits, syndrome edits, an optional run and queries.
  task automatic test_random();
    int unsigned sent;
    int unsigned a, b, sa, sb, n;
    logic [31:0] wt;
    logic [7:0] fl;
    logic bnd;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      n = $urandom_range(0, 5);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) < 7) begin
          // Symmetric edge between pool detectors, or a boundary edge.
          a = pool[$urandom_range(0, POOL_N - 1)];
          b = ($urandom_range(0, 15) == 0) ? a : pool[$urandom_range(0, POOL_N - 1)];
          sa = $urandom_range(0, NSLOT - 1);
          sb = $urandom_range(0, NSLOT - 1);
          wt = $urandom;
          fl = 8'($urandom);
          bnd = ($urandom_range(0, 4) == 0);
          load_edge(a, sa, b, bnd, 1'b1, wt, fl);
          sent++;
          if (!bnd && a != b) begin
            load_edge(b, sb, a, 1'b0, 1'b1, wt, fl);
            sent++;
          end
        end else begin
          load_edge($urandom_range(0, NDET - 1), $urandom_range(0, NSLOT - 1),
                    $urandom_range(0, NDET - 1), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), $urandom, 8'($urandom));
          sent++;
        end
      end
      if ($urandom_range(0, 1) == 0) begin
        for (int k = 0; k < POOL_N; k++)
          if (syn_q[pool[k]]) begin
            load_syn(pool[k], 1'b0);
            sent++;
          end
      end
      n = $urandom_range(1, 5);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 7) == 0) load_syn($urandom_range(0, NDET - 1), 1'b0);
        else load_syn(pool[$urandom_range(0, POOL_N - 1)], $urandom_range(0, 3) != 0);
        sent++;
      end
      if ($urandom_range(0, 7) != 0) begin
        run_filter();
        sent++;
      end
      n = $urandom_range(1, 5);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 4) == 0) query($urandom_range(0, NDET - 1));
        else query(pool[$urandom_range(0, POOL_N - 1)]);
        sent++;
      end
      if ($urandom_range(0, 19) == 0) drain();
    end
    no_gaps = 0;
  endtask

  initial begin
    for (int i = 0; i < NDET; i++) begin
      syn_q[i] = 1'b0;
      deg_q[i] = '0;
      comp_q[i] = '0;
      resid_q[i] = 1'b0;
      pair_q[i] = 1'b0;
      written_q[i] = '0;
    end
    for (int i = 0; i < NDET*NSLOT; i++) graph_q[i] = '0;
    bnd_cnt = '0;
    flip_acc = '0;
    removed_cnt = '0;
    rst_ni = 1'b0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_pool_setup();
    test_directed();
    test_random();
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Runs are long; allow well over the slowest expected run.
  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
rtl/iep_pkg.sv
rtl/iep_if.sv
rtl/iep_ram.sv
rtl/isolated_error_predecoder_unit.sv
tb/testbench.sv
